// ----- rtl/mrfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reply frame checker package
// Shared item types, check results and protocol constants.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    localparam int BURST_BYTES_DEF = 64;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [7:0]  HEADER_BYTE     = 8'hC5;
    localparam logic [7:0]  TRAILER_BYTE    = 8'h5C;
    localparam logic [7:0]  FUNC_POSITION   = 8'h30;
    localparam logic [7:0]  ARRIVED_CODE    = 8'h01;
    localparam logic [3:0]  MIN_FRAME_LEN   = 4'd6;
    localparam logic [3:0]  ARRIVED_MIN_LEN = 4'd7;
    localparam logic [3:0]  MAX_FRAME_LEN   = 4'd8;
    localparam logic [3:0]  LEN_SIX         = 4'd6;
    localparam logic [3:0]  LEN_SEVEN       = 4'd7;

    localparam logic ITEM_FRAME = 1'b0;
    localparam logic ITEM_TICK  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [3:0] length_code;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
        logic [7:0] byte6;
        logic [7:0] byte7;
    } in_item_t;

    typedef struct packed {
        logic       arrived;
        logic [7:0] error_byte;
        logic       frame_accepted;
        logic       burst_done;
        logic [6:0] buffered_bytes;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] error;
        logic       arrived_update;
        logic       arrived_value;
    } chk_t;

endpackage

// ----- rtl/motor_reply_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reply frame checker
// Checks received motor reply frames, tracks status and burst byte count.
// ----------------------------------------------------------------------------
// A result is worked out from the item held in the input register through one
// pass of checksum and state update logic and is offered from the result register.
// Throughput: one item per cycle; the input register and the result register
// form a two-entry pipeline that keeps moving while the result is not stalled.
// Reset: all status, the burst count, the idle timer and both stage valids
// clear; the timeout register returns to 1000 ticks.
module motor_reply_frame_checker #(
    parameter int BURST_BYTES = mrfc_pkg::BURST_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mrfc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output mrfc_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);
    import mrfc_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [15:0] timeout_reg;
    logic        advance;
    logic        accept;
    chk_t        chk;
    out_item_t   result;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    mrfc_frame_check u_check (
        .item (in_item_reg),
        .chk  (chk)
    );

    mrfc_state #(
        .BURST_BYTES (BURST_BYTES)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (in_item_reg),
        .chk     (chk),
        .timeout (timeout_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    // A held input item is never dropped: it either moves on or stays.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    // A transfer into the result register always follows a held input item.
    a_advance_src: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(in_valid_reg))
        else $error("result without input item");

endmodule

// ----- rtl/mrfc_frame_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reply frame check
// Header, trailer, length and additive checksum checks for one frame.
// ----------------------------------------------------------------------------
module mrfc_frame_check (
    input  mrfc_pkg::in_item_t item,
    output mrfc_pkg::chk_t     chk
);
    import mrfc_pkg::*;

    logic [7:0] sum4;
    logic [7:0] sum5;
    logic [7:0] sum6;
    logic [7:0] sum_sel;
    logic [7:0] csum_sel;
    logic [7:0] trail_sel;
    logic       len_ok;

    always_comb
    begin
        sum4 = item.byte0 + item.byte1 + item.byte2 + item.byte3;
        sum5 = sum4 + item.byte4;
        sum6 = sum5 + item.byte5;
        case (item.length_code)
            LEN_SIX:
            begin
                sum_sel   = sum4;
                csum_sel  = item.byte4;
                trail_sel = item.byte5;
            end
            LEN_SEVEN:
            begin
                sum_sel   = sum5;
                csum_sel  = item.byte5;
                trail_sel = item.byte6;
            end
            default:
            begin
                sum_sel   = sum6;
                csum_sel  = item.byte6;
                trail_sel = item.byte7;
            end
        endcase
        len_ok = item.length_code inside {[MIN_FRAME_LEN:MAX_FRAME_LEN]};

        chk.accepted       = len_ok && (item.byte0 == HEADER_BYTE)
                             && (trail_sel == TRAILER_BYTE) && (sum_sel == csum_sel);
        chk.error          = item.byte3;
        chk.arrived_update = (item.byte2 == FUNC_POSITION)
                             && (item.length_code >= ARRIVED_MIN_LEN);
        chk.arrived_value  = (item.byte4 == ARRIVED_CODE);
    end

endmodule

// ----- rtl/mrfc_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor reply frame checker state
// Status flags, burst byte count and idle timer, updated once per item.
// ----------------------------------------------------------------------------
module mrfc_state #(
    parameter int BURST_BYTES = mrfc_pkg::BURST_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mrfc_pkg::in_item_t  item,
    input  mrfc_pkg::chk_t      chk,
    input  logic [15:0]         timeout,
    output mrfc_pkg::out_item_t result
);
    import mrfc_pkg::*;

    localparam int CNT_W = $clog2(BURST_BYTES + 1);

    logic             arrived_reg, arrived_next;
    logic [7:0]       error_reg, error_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             timer_reg, timer_next;
    logic [15:0]      idle_reg, idle_next;
    logic             done_reg, done_next;
    logic             accepted;
    logic             ovf;
    logic [15:0]      limit;
    logic [16:0]      idle_inc;
    logic [CNT_W:0]   cnt_sum;
    logic [CNT_W+6:0] cnt_wide;

    always_comb
    begin
        arrived_next = arrived_reg;
        error_next   = error_reg;
        count_next   = count_reg;
        timer_next   = timer_reg;
        idle_next    = idle_reg;
        done_next    = done_reg;
        accepted     = 1'b0;
        ovf          = 1'b0;
        limit        = (timeout == 16'd0) ? 16'd1 : timeout;
        idle_inc     = {1'b0, idle_reg} + 17'd1;
        cnt_sum      = (CNT_W+1)'(count_reg) + (CNT_W+1)'(item.length_code);

        if (item.func == ITEM_FRAME)
        begin
            if (item.length_code inside {[4'd1:MAX_FRAME_LEN]})
            begin
                accepted = chk.accepted;
                if (chk.accepted)
                begin
                    error_next = chk.error;
                    if (chk.arrived_update)
                    begin
                        arrived_next = chk.arrived_value;
                    end
                end
                if (count_reg == '0)
                begin
                    timer_next = 1'b1;
                end
                if (cnt_sum <= (CNT_W+1)'(BURST_BYTES))
                begin
                    count_next = cnt_sum[CNT_W-1:0];
                    idle_next  = 16'd0;
                end
                else
                begin
                    count_next = '0;
                    ovf        = 1'b1;
                end
            end
        end
        else if (timer_reg)
        begin
            if (idle_inc >= {1'b0, limit})
            begin
                idle_next = 16'd0;
                if (count_reg != '0)
                begin
                    done_next  = 1'b1;
                    timer_next = 1'b0;
                    count_next = '0;
                end
            end
            else
            begin
                idle_next = idle_inc[15:0];
            end
        end

        cnt_wide = {7'd0, count_next};

        result.arrived        = arrived_next;
        result.error_byte     = error_next;
        result.frame_accepted = accepted;
        result.burst_done     = done_next;
        result.buffered_bytes = cnt_wide[6:0];
        result.overflow       = ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrived_reg <= 1'b0;
            error_reg   <= 8'd0;
            count_reg   <= '0;
            timer_reg   <= 1'b0;
            idle_reg    <= 16'd0;
            done_reg    <= 1'b0;
        end
        else if (step)
        begin
            arrived_reg <= arrived_next;
            error_reg   <= error_next;
            count_reg   <= count_next;
            timer_reg   <= timer_next;
            idle_reg    <= idle_next;
            done_reg    <= done_next;
        end
    end

    // The burst count never passes its bound.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BURST_BYTES))
        else $error("burst count above bound");

    // A non-empty burst always has its idle timer running.
    a_count_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> timer_reg)
        else $error("bytes gathered with idle timer stopped");

    // The done flag is sticky.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("done flag cleared");

    // An overflow leaves the burst empty.
    a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ovf) |=> (count_reg == '0))
        else $error("count not cleared after overflow");

endmodule
